/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define NFTK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define NFTK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NFTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nftk_pkg.sv */
`default_nettype none

package nftk_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int RD_IDX_W  = 5;
  localparam int CMP_W     = (CNT_W > RD_IDX_W) ? CNT_W : RD_IDX_W;
  localparam int KEY_SHIFT = 16;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // insert_slot code for "no slot written"
  localparam logic [5:0] SLOT_NONE = 6'(ENTRIES);

  typedef struct packed {
    logic [1:0]          command;
    logic [15:0]         rec_date;
    logic [15:0]         rec_clock;
    logic [31:0]         rec_size;
    logic [15:0]         rec_handle;
    logic [RD_IDX_W-1:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  entry_count;
    logic [5:0]  insert_slot;
    logic        entry_valid;
    logic [15:0] out_date;
    logic [15:0] out_clock;
    logic [31:0] out_size;
    logic [15:0] out_handle;
  } out_res_t;

  // one table row as stored in RAM
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] size;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_FULL_CHK,
    S_SHIFT,
    S_PLACE
  } state_t;

endpackage

`default_nettype wire

/* sv/newest_first_topk_insert_core.sv */
`default_nettype none

// Newest-first record table of ENTRIES rows, held in one RAM (key, size,
// handle) and sorted by key = date:clock, largest first. A request is taken
// when start is high and busy is low; its single result shows on out_res for
// exactly one cycle with out_valid high and cannot be stalled, so the
// receiver must take it then. Clear and unused commands, and reads past the
// count, answer straight from S_IDLE; a read of a valid row first passes
// through S_RD_WAIT for the registered RAM read. An insert walks up from the
// bottom of the table one row per cycle, reading row j-1 and writing it to
// row j until a larger key is found or row 0 is reached. A full table first
// checks its last row in S_FULL_CHK, which replaces the move of the row that
// falls off; an insert older than every row there is dropped, and an insert
// into an empty table writes row 0 from S_IDLE. That one-row-per-cycle walk
// through the RAM's single write port sets the insert time. busy drops in
// the cycle the result is shown, so the next request may be taken while it
// is out. Rows are never cleared: only rows below the count are ever used.
module newest_first_topk_insert_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire nftk_pkg::in_req_t  in_req,
  output logic                    out_valid,
  output nftk_pkg::out_res_t      out_res
);

  import nftk_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;     // row being written during the walk
  entry_t           rec_r, rec_nxt;     // record being inserted
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, res_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  entry_t           new_rec;
  logic             rd_hit;
  logic             older;              // row read has a strictly greater key
  logic [CNT_W-1:0] count_inc;

  nftk_ram #(
    .DEPTH (ENTRIES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign new_rec.key    = {in_req.rec_date, in_req.rec_clock};
  assign new_rec.size   = in_req.rec_size;
  assign new_rec.handle = in_req.rec_handle;

  assign rd_hit    = CMP_W'(in_req.read_index) < CMP_W'(count_r);
  assign older     = mem_rdata.key > rec_r.key;
  // count saturates at ENTRIES
  assign count_inc = (count_r == CNT_W'(ENTRIES)) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    rec_r     <= rec_nxt;
    out_res_r <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    rec_nxt       = rec_r;
    out_valid_nxt = 1'b0;
    res_nxt       = '0;
    res_nxt.insert_slot = SLOT_NONE;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = rec_r;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_req.command)
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_INSERT: begin
              rec_nxt = new_rec;
              if (count_r == CNT_W'(ENTRIES)) begin
                // full: check the last row before shifting anything
                mem_raddr = IDX_W'(ENTRIES - 1);
                state_nxt = S_FULL_CHK;
              end else if (count_r == '0) begin
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wdata     = new_rec;
                count_nxt     = count_inc;
                res_nxt.insert_slot = '0;
                out_valid_nxt = 1'b1;
              end else begin
                mem_raddr = IDX_W'(count_r - 1'b1);
                pos_nxt   = IDX_W'(count_r);
                state_nxt = S_SHIFT;
              end
            end
            CMD_READ: begin
              if (rd_hit) begin
                mem_raddr = IDX_W'(in_req.read_index);
                state_nxt = S_RD_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        res_nxt.entry_valid = 1'b1;
        res_nxt.out_date    = mem_rdata.key[31:KEY_SHIFT];
        res_nxt.out_clock   = mem_rdata.key[KEY_SHIFT-1:0];
        res_nxt.out_size    = mem_rdata.size;
        res_nxt.out_handle  = mem_rdata.handle;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      S_FULL_CHK: begin
        if (older) begin
          // older than every row: dropped
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // last row falls off; walk starts by overwriting it with the row above
          pos_nxt   = IDX_W'(ENTRIES - 1);
          mem_raddr = IDX_W'(ENTRIES - 2);
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // mem_rdata holds row pos_r-1
        mem_we = 1'b1;
        if (older) begin
          mem_wdata     = rec_r;
          count_nxt     = count_inc;
          res_nxt.insert_slot = 6'(pos_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - 1'b1;
          mem_raddr = pos_r - IDX_W'(2);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        mem_we        = 1'b1;
        mem_wdata     = rec_r;
        count_nxt     = count_inc;
        res_nxt.insert_slot = 6'(pos_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_nxt.entry_count = 6'(count_nxt);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "assert_macros.svh"

  `NFTK_ASSERT(a_count_range, count_r <= CNT_W'(ENTRIES), "count above table size")
  `NFTK_ASSERT_IMPL(a_count_with_result, !$stable(count_r), out_valid_r,
                    "count changed without a result")
  `NFTK_ASSERT_IMPL(a_result_idle, out_valid_r, !busy, "result shown while busy")
  `NFTK_ASSERT_NEXT(a_clear_one_cycle, start && !busy && in_req.command == CMD_CLEAR,
                    out_valid_r && count_r == '0, "clear did not finish in one cycle")
  `NFTK_ASSERT_IMPL(a_walk_no_overlap, state_r == S_SHIFT && mem_we, mem_waddr != mem_raddr,
                    "walk reads the row it writes")

endmodule

`default_nettype wire

/* sv/nftk_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// Read returns the old contents if the same address is written.
module nftk_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 80,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
